>>> design/dsph_pkg.sv
// Shared types, constants and helper functions of the digit-string prime hash.
`timescale 1ns / 1ps
`default_nettype none

package dsph_pkg;

  // Default number of trailing decimal digits that are kept.
  localparam int unsigned DIGIT_LIMIT_DEF = 18;

  // Width of the configuration registers, the remainders and the result.
  localparam int unsigned REM_W = 31;

  // Configuration port index width and register reset values.
  localparam int unsigned CFG_IDX_W        = 1;
  localparam logic [REM_W-1:0] PRIME_RESET  = 31'd51797;
  localparam logic [REM_W-1:0] BUCKET_RESET = 31'd1;

  // ASCII codes that bound the decimal digits.
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRIME_MODULUS = 1'b0,
    CFG_BUCKET_COUNT  = 1'b1
  } dsph_cfg_idx_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_MODP,
    ST_MODB,
    ST_HOLD
  } dsph_state_e;

  // Control of the decimal digit shift register.
  typedef struct packed {
    logic       load;   // shift a new digit in at the low end
    logic       drain;  // shift out the top digit, zero in at the low end
    logic [3:0] digit;  // digit to load
  } dsph_shift_ctl_t;

  // Ten to the power n, evaluated at elaboration.
  function automatic logic [63:0] pow10(input int unsigned n);
    logic [63:0] p;
    p = 64'd1;
    for (int unsigned k = 0; k < n; k++) begin
      p = p * 64'd10;
    end
    return p;
  endfunction

endpackage

`default_nettype wire

>>> design/dsph_digit_shift.sv
// Decimal digit shift register that holds the trailing digits of the string.
`timescale 1ns / 1ps
`default_nettype none

module dsph_digit_shift
  import dsph_pkg::*;
#(
  parameter int unsigned DIGIT_LIMIT = DIGIT_LIMIT_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire dsph_shift_ctl_t ctl_i,
  output logic [3:0]           top_digit_o
);

  logic [DIGIT_LIMIT-1:0][3:0] digits_q, digits_d;

  // A load drops the oldest digit; a drain hands out the most significant
  // digit and refills with zeros, so a full drain also clears the register.
  always_comb begin
    digits_d = digits_q;
    if (ctl_i.load || ctl_i.drain) begin
      for (int unsigned i = DIGIT_LIMIT - 1; i > 0; i--) begin
        digits_d[i] = digits_q[i-1];
      end
      digits_d[0] = ctl_i.load ? ctl_i.digit : 4'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digits_q <= '0;
    end else begin
      digits_q <= digits_d;
    end
  end

  assign top_digit_o = digits_q[DIGIT_LIMIT-1];

endmodule

`default_nettype wire

>>> design/dsph_mod_step.sv
// One restoring remainder step: shift in a dividend bit, subtract the divisor if it fits.
`timescale 1ns / 1ps
`default_nettype none

module dsph_mod_step
  import dsph_pkg::*;
(
  input  wire logic [REM_W-1:0] rem_i,
  input  wire logic             bit_i,
  input  wire logic [REM_W-1:0] divisor_i,
  output logic [REM_W-1:0]      rem_o
);

  logic [REM_W:0] trial;
  logic [REM_W:0] diff;

  // The partial remainder stays below the divisor, so both arms fit REM_W bits.
  always_comb begin
    trial = {rem_i, bit_i};
    diff  = trial - {1'b0, divisor_i};
    if (trial >= {1'b0, divisor_i}) begin
      rem_o = diff[REM_W-1:0];
    end else begin
      rem_o = trial[REM_W-1:0];
    end
  end

endmodule

`default_nettype wire

>>> design/digit_string_prime_hash.sv
// Top level of the digit-string prime hash: sequencer, datapath registers and config.
`timescale 1ns / 1ps
`default_nettype none

// Digit-string prime hash. Bytes of a string arrive one item at a time; ASCII
// digits are collected into a decimal shift register that keeps the last
// DIGIT_LIMIT digits, other bytes are dropped. A byte that is not marked last
// does not stall the input. On the byte marked last the block converts the
// digits to binary, reduces the number (ACC_W bits wide, ACC_W being the bit
// width of 10^DIGIT_LIMIT - 1, 60 for 18 digits) modulo prime_modulus one
// bit a cycle, then modulo bucket_count, and presents ((n mod prime) mod
// buckets) + 1 in the output register once that register is free.
// These bit steps all run through one shared restoring remainder unit, and
// the input stalls until the result sits in the output register. The input
// is taken again while a result still waits to be delivered. A zero
// prime_modulus or bucket_count acts as one. Configuration writes are taken
// only while the block is idle.
module digit_string_prime_hash
  import dsph_pkg::*;
#(
  parameter int unsigned DIGIT_LIMIT = DIGIT_LIMIT_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // Input channel
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [7:0]           char_byte_i,
  input  wire logic                 last_char_i,
  // Output channel
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [REM_W-1:0]          bucket_value_o,
  // Configuration write channel
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [REM_W-1:0]     cfg_data_i
);

  localparam int unsigned ACC_W = $clog2(pow10(DIGIT_LIMIT));
  localparam int unsigned DIV_W = (ACC_W > REM_W) ? ACC_W : REM_W;
  localparam int unsigned CNT_W = $clog2(DIV_W);

  dsph_state_e      state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0] div_q, div_d;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [REM_W-1:0] out_q, out_d;
  logic             out_valid_q, out_valid_d;
  logic [REM_W-1:0] prime_q, bucket_q;

  logic [REM_W-1:0] prime_eff, bucket_eff;
  logic [REM_W-1:0] divisor;
  logic [REM_W-1:0] step_rem;
  logic [3:0]       top_digit;
  logic [ACC_W-1:0] acc_bin;
  logic [ACC_W-1:0] mul10;
  logic             in_fire;
  logic             out_fire;
  logic             out_free;
  dsph_shift_ctl_t  shift_ctl;

  // Configuration registers; a zero modulus behaves as one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prime_q  <= PRIME_RESET;
      bucket_q <= BUCKET_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_PRIME_MODULUS: prime_q  <= cfg_data_i;
        CFG_BUCKET_COUNT:  bucket_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = (state_q == ST_IDLE);
  assign prime_eff   = (prime_q == '0) ? REM_W'(1) : prime_q;
  assign bucket_eff  = (bucket_q == '0) ? REM_W'(1) : bucket_q;

  // Handshakes.
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_fire    = out_valid_q && !out_stall_i;
  assign out_free    = !out_valid_q || !out_stall_i;

  // Horner step of the decimal to binary conversion.
  assign acc_bin = div_q[ACC_W-1:0];
  assign mul10   = (acc_bin << 3) + (acc_bin << 1) + ACC_W'(top_digit);

  // Shared remainder unit, first against the prime, then against the buckets.
  assign divisor = (state_q == ST_MODB) ? bucket_eff : prime_eff;

  dsph_mod_step u_mod_step (
    .rem_i     (rem_q),
    .bit_i     (div_q[DIV_W-1]),
    .divisor_i (divisor),
    .rem_o     (step_rem)
  );

  dsph_digit_shift #(
    .DIGIT_LIMIT (DIGIT_LIMIT)
  ) u_digit_shift (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (shift_ctl),
    .top_digit_o (top_digit)
  );

  // Sequencer: next state, datapath loads and digit register control.
  always_comb begin
    state_d         = state_q;
    cnt_d           = cnt_q;
    div_d           = div_q;
    rem_d           = rem_q;
    out_d           = out_q;
    out_valid_d     = out_fire ? 1'b0 : out_valid_q;
    shift_ctl.load  = 1'b0;
    shift_ctl.drain = 1'b0;
    shift_ctl.digit = 4'(char_byte_i - CHAR_ZERO);

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          shift_ctl.load = char_byte_i inside {[CHAR_ZERO:CHAR_NINE]};
          if (last_char_i) begin
            div_d   = '0;
            cnt_d   = CNT_W'(DIGIT_LIMIT - 1);
            state_d = ST_CONV;
          end
        end
      end
      ST_CONV: begin
        shift_ctl.drain = 1'b1;
        div_d           = DIV_W'(mul10);
        if (cnt_q == '0) begin
          rem_d   = '0;
          cnt_d   = CNT_W'(DIV_W - 1);
          state_d = ST_MODP;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_MODP: begin
        div_d = div_q << 1;
        rem_d = step_rem;
        if (cnt_q == '0) begin
          // Left-align the prime remainder as the next dividend.
          div_d   = DIV_W'(step_rem) << (DIV_W - REM_W);
          rem_d   = '0;
          cnt_d   = CNT_W'(REM_W - 1);
          state_d = ST_MODB;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_MODB: begin
        div_d = div_q << 1;
        rem_d = step_rem;
        if (cnt_q == '0) begin
          state_d = ST_HOLD;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_d       = rem_q + 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    rem_q <= rem_d;
    out_q <= out_d;
  end

  assign out_valid_o    = out_valid_q;
  assign bucket_value_o = out_q;

  // A last byte starts the conversion with a full digit count.
  a_last_starts_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && last_char_i |=> state_q == ST_CONV && cnt_q == CNT_W'(DIGIT_LIMIT - 1))
    else $error("last byte did not start the conversion");

  // The partial remainder stays below the prime during the first reduction.
  a_rem_below_prime: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MODP |-> rem_q < prime_eff)
    else $error("partial remainder reached the prime modulus");

  // The final bucket step leaves a remainder below the bucket count.
  a_bucket_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MODB && cnt_q == '0 |=> state_q == ST_HOLD && rem_q < bucket_eff)
    else $error("bucket reduction ended with a bad remainder");

  // A delivered result is never zero.
  a_result_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q != '0)
    else $error("result of zero presented");

endmodule

`default_nettype wire

>>> sim/digit_string_prime_hash_tb.sv
// Self-checking testbench for the digit-string prime hash block.
`timescale 1ns / 1ps

module digit_string_prime_hash_tb;
  import dsph_pkg::*;

  // Ten to the seventeenth: the weight of the oldest digit that survives a shift.
  localparam logic [63:0] KEEP_WEIGHT = 64'd100000000000000000;
  localparam logic [REM_W-1:0] REG_MAX = '1;
  // Quiet cycles after the last result, longer than the worst last-byte latency.
  localparam int unsigned SETTLE_CYCLES = 150;
  localparam int unsigned TIMEOUT_NS = 4_000_000;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_item_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [7:0]           char_byte_i = 8'h00;
  logic                 last_char_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [REM_W-1:0]     bucket_value_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_PRIME_MODULUS;
  logic [REM_W-1:0]     cfg_data_i = '0;

  // Items waiting to be driven and results waiting to arrive.
  char_item_t       char_q[$];
  logic [REM_W-1:0] bucket_q[$];

  // Shadow copy of the block's registers and digit accumulator.
  logic [REM_W-1:0] prime_reg = PRIME_RESET;
  logic [REM_W-1:0] bucket_reg = BUCKET_RESET;
  logic [59:0]      digit_acc = '0;

  // Handshakes seen at the last rising edge, used by the falling-edge drivers.
  logic             in_taken = 1'b0;
  logic             cfg_taken = 1'b0;
  logic [REM_W-1:0] want_bucket;
  char_item_t       next_item;
  int unsigned      send_idle_pct = 0;
  int unsigned      recv_stall_pct = 0;
  int unsigned      fail_count = 0;

  digit_string_prime_hash u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .char_byte_i    (char_byte_i),
    .last_char_i    (last_char_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .bucket_value_o (bucket_value_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
  endfunction

  // Bucket of a number; a zero modulus or bucket count behaves as one.
  function automatic logic [REM_W-1:0] hash_bucket(input logic [59:0] num,
                                                   input logic [REM_W-1:0] p,
                                                   input logic [REM_W-1:0] b);
    logic [63:0] pm;
    logic [63:0] bm;
    logic [63:0] r;
    pm = (p == '0) ? 64'd1 : {33'd0, p};
    bm = (b == '0) ? 64'd1 : {33'd0, b};
    r = ({4'd0, num} % pm) % bm + 64'd1;
    return r[REM_W-1:0];
  endfunction

  // Monitor: track register writes, check results, fold in each accepted item and predict on the last.
  always @(posedge clk_i) begin
    in_taken = in_valid_i && !in_stall_o;
    cfg_taken = cfg_valid_i && cfg_ready_o;

    if (cfg_taken) begin
      case (dsph_cfg_idx_e'(cfg_index_i))
        CFG_PRIME_MODULUS: prime_reg = cfg_data_i;
        CFG_BUCKET_COUNT:  bucket_reg = cfg_data_i;
        default: ;
      endcase
    end

    if (out_valid_o && !out_stall_i) begin
      if (bucket_q.size() == 0) begin
        $error("unexpected result: bucket_value actual %0d", bucket_value_o);
        fail_count++;
      end else begin
        want_bucket = bucket_q.pop_front();
        if (bucket_value_o !== want_bucket) begin
          $error("bucket_value mismatch: expected %0d, actual %0d",
                 want_bucket, bucket_value_o);
          fail_count++;
        end
      end
    end

    if (in_taken) begin
      if (is_digit(char_byte_i)) begin
        digit_acc = 60'(({4'd0, digit_acc} % KEEP_WEIGHT) * 64'd10
                        + 64'(char_byte_i - CHAR_ZERO));
      end
      if (last_char_i) begin
        bucket_q.push_back(hash_bucket(digit_acc, prime_reg, bucket_reg));
        digit_acc = '0;
      end
    end
  end

  // Driver: stall the output at random; present the next item once the current one is taken, with random gaps.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      if (!in_valid_i || in_taken) begin
        if (char_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item = char_q.pop_front();
          in_valid_i <= 1'b1;
          char_byte_i <= next_item.ch;
          last_char_i <= next_item.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic push_char(input logic [7:0] ch, input logic last);
    char_q.push_back('{ch: ch, last: last});
  endtask

  // Wait until every item is sent and every result is in, then let the block settle.
  task automatic wait_idle();
    while (char_q.size() != 0 || in_valid_i || bucket_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input dsph_cfg_idx_e idx, input logic [REM_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do begin
      @(negedge clk_i);
    end while (!cfg_taken);
    cfg_valid_i <= 1'b0;
  endtask

  // Queue one string: mostly digit runs with some separators, some digit-free
  // strings, and some raw byte noise. Every queued byte is counted.
  task automatic queue_string(inout int unsigned counted);
    int unsigned kind;
    int unsigned len;
    logic [7:0]  b;
    logic        fin;
    kind = $urandom_range(99);
    if (kind < 70) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(19, 26) : $urandom_range(1, 12);
    end else if (kind < 85) begin
      len = $urandom_range(1, 6);
    end else begin
      len = $urandom_range(1, 40);
    end
    for (int unsigned i = 0; i < len; i++) begin
      if (kind < 70 && $urandom_range(9) != 0) begin
        b = CHAR_ZERO + 8'($urandom_range(9));
      end else if (kind < 85) begin
        b = 8'($urandom_range(255));
        while (is_digit(b)) b = 8'($urandom_range(255));
      end else begin
        b = 8'($urandom_range(255));
      end
      fin = (i == len - 1);
      push_char(b, fin);
      counted++;
    end
  endtask

  // One phase: settle, set both registers, choose the idling mix, queue strings.
  task automatic run_phase(input logic [REM_W-1:0] prime, input logic [REM_W-1:0] bucket,
                           input int unsigned send_pct, input int unsigned recv_pct,
                           input int unsigned n_items);
    int unsigned counted;
    counted = 0;
    wait_idle();
    write_reg(CFG_PRIME_MODULUS, prime);
    write_reg(CFG_BUCKET_COUNT, bucket);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    while (counted < n_items) queue_string(counted);
  endtask

  // Stimulus sequence.
  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset register values: top byte value, then a digit-free string ending on zero.
    push_char(8'hFF, 1'b0);
    push_char(8'h00, 1'b1);

    // Widest registers; bytes just outside the digit range, then more than
    // eighteen nines so the accumulator holds its largest value.
    run_phase(REG_MAX, REG_MAX, 0, 0, 0);
    push_char(8'h2F, 1'b0);
    push_char(8'h3A, 1'b0);
    push_char(CHAR_NINE, 1'b1);
    for (int i = 0; i < 19; i++) push_char(CHAR_NINE, i == 18);

    // Random strings across register settings and idling mixes.
    run_phase(REG_MAX, REG_MAX, 0, 0, 150);
    run_phase(31'd51797, 31'd1000, 52, 0, 150);
    run_phase('0, '0, 0, 52, 100);
    run_phase(31'd1, REG_MAX, 36, 36, 100);
    run_phase(31'($urandom), 31'($urandom_range(1, 65535)), 52, 0, 150);
    run_phase(31'($urandom_range(2, 200)), 31'($urandom_range(2, 50)), 0, 52, 150);
    run_phase(REG_MAX, 31'd1, 36, 36, 100);
    run_phase(31'($urandom), 31'($urandom), 36, 36, 250);

    wait_idle();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #(TIMEOUT_NS);
    $display("tb: failure");
    $finish;
  end

endmodule
